// ===== sv/uart_8n1_half_duplex_transceiver_macros.svh =====
// Assertion macros for the 8N1 transceiver.
// Used by files that carry concurrent checks; they expect aclk and aresetn in scope.
`ifndef UART_8N1_HALF_DUPLEX_TRANSCEIVER_MACROS_SVH
`define UART_8N1_HALF_DUPLEX_TRANSCEIVER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define U8T_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("u8t check failed");

// Next-cycle implication, checked only out of reset.
`define U8T_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("u8t check failed");

`endif

// ===== sv/u8t_pkg.sv =====
// Shared types and constants for the 8N1 half-duplex transceiver.
// No dependencies; imported by every module of the block.
package u8t_pkg;

    localparam logic [15:0] RESET_BIT_PERIOD  = 16'd104;
    localparam logic [15:0] RESET_HALF_PERIOD = 16'd52;
    localparam logic [3:0]  FRAME_BITS        = 4'd10;

    // Configuration register indexes
    localparam logic [7:0] CFG_BIT_PERIOD  = 8'd0;
    localparam logic [7:0] CFG_HALF_PERIOD = 8'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RX   = 2'd1,
        PH_TX   = 2'd2
    } phase_t;

    typedef struct packed {
        logic       rx_line;
        logic       tx_request;
        logic [7:0] tx_byte;
    } in_t;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_busy;
        logic       tx_busy;
    } out_t;

endpackage

// ===== sv/u8t_core.sv =====
// Frame sequencer: shared bit timer, receive and transmit shifters, status.
// Depends on u8t_pkg and the block's assertion macro header.
`include "uart_8n1_half_duplex_transceiver_macros.svh"

module u8t_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  u8t_pkg::in_t   in_data,
    input  logic [15:0]    bit_period,
    input  logic [15:0]    half_bit_period,
    output u8t_pkg::out_t  result
);
    import u8t_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [3:0]  bits_left_reg, bits_left_next;
    logic [9:0]  rx_shift_reg, rx_shift_next;
    logic [9:0]  tx_shift_reg, tx_shift_next;
    logic        tx_pending_reg, tx_pending_next;
    logic        line_prev_reg;
    logic        line_out_reg, line_out_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        rx_valid_next;

    logic        start_edge;
    logic [15:0] tick_dec;
    logic        tick_done;
    logic [3:0]  bits_dec;
    logic        req_take;
    logic        pending_now;
    logic [9:0]  rx_shift_in;
    logic        frame_ok;

    assign start_edge  = line_prev_reg & ~in_data.rx_line;
    assign tick_dec    = tick_count_reg - 16'd1;
    assign tick_done   = (tick_dec == 16'd0);
    assign bits_dec    = bits_left_reg - 4'd1;
    // a new request is taken unless one is queued or a frame is going out
    assign req_take    = in_data.tx_request & ~tx_pending_reg & (phase_reg != PH_TX);
    assign pending_now = tx_pending_reg | req_take;
    assign rx_shift_in = {in_data.rx_line, rx_shift_reg[9:1]};
    // start bit lands in bit 0, stop bit in bit 9
    assign frame_ok    = rx_shift_in[9] & ~rx_shift_in[0];

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_RX: begin
                if (tick_done && bits_dec == 4'd0) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_TX: begin
                if (tick_done && bits_left_reg == 4'd0) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                // receive wins over a queued transmit
                if (start_edge) begin
                    phase_next = PH_RX;
                end else if (pending_now) begin
                    phase_next = PH_TX;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        tick_count_next = tick_count_reg;
        bits_left_next  = bits_left_reg;
        rx_shift_next   = rx_shift_reg;
        tx_shift_next   = req_take ? {1'b1, in_data.tx_byte, 1'b0} : tx_shift_reg;
        tx_pending_next = pending_now;
        line_out_next   = line_out_reg;
        rx_hold_next    = rx_hold_reg;
        rx_valid_next   = 1'b0;
        unique case (phase_reg)
            PH_RX: begin
                tick_count_next = tick_dec;
                if (tick_done) begin
                    tick_count_next = bit_period;
                    rx_shift_next   = rx_shift_in;
                    bits_left_next  = bits_dec;
                    if (bits_dec == 4'd0 && frame_ok) begin
                        rx_hold_next  = rx_shift_in[8:1];
                        rx_valid_next = 1'b1;
                    end
                end
            end
            PH_TX: begin
                tick_count_next = tick_dec;
                if (tick_done) begin
                    tick_count_next = bit_period;
                    if (bits_left_reg == 4'd0) begin
                        line_out_next = 1'b1;
                    end else begin
                        line_out_next  = tx_shift_reg[0];
                        tx_shift_next  = {1'b1, tx_shift_reg[9:1]};
                        bits_left_next = bits_dec;
                    end
                end
            end
            default: begin
                if (start_edge) begin
                    tick_count_next = half_bit_period;
                    bits_left_next  = FRAME_BITS;
                end else if (pending_now) begin
                    tx_pending_next = 1'b0;
                    tick_count_next = bit_period;
                    bits_left_next  = FRAME_BITS;
                    line_out_next   = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        result.tx_line  = line_out_next;
        result.rx_byte  = rx_hold_next;
        result.rx_valid = rx_valid_next;
        result.rx_busy  = (phase_next == PH_RX);
        result.tx_busy  = (phase_next == PH_TX) | tx_pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 16'd0;
            bits_left_reg  <= 4'd0;
            tx_pending_reg <= 1'b0;
            line_prev_reg  <= 1'b1;
            line_out_reg   <= 1'b1;
            rx_hold_reg    <= 8'd0;
        end else if (in_fire) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bits_left_reg  <= bits_left_next;
            tx_pending_reg <= tx_pending_next;
            line_prev_reg  <= in_data.rx_line;
            line_out_reg   <= line_out_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    // shifters are fully loaded before they are looked at
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rx_shift_reg <= rx_shift_next;
            tx_shift_reg <= tx_shift_next;
        end
    end

    `U8T_ASSERT_IMP(a_no_pending_in_tx, phase_reg == PH_TX, !tx_pending_reg)
    `U8T_ASSERT_IMP(a_bits_in_range, phase_reg != PH_IDLE, bits_left_reg <= FRAME_BITS)
    `U8T_ASSERT_NEXT(a_valid_ends_rx, in_fire && result.rx_valid, phase_reg == PH_IDLE)

endmodule

// ===== sv/u8t_obuf.sv =====
// Result register between the sequencer and the m_ channel.
// Depends on u8t_pkg.
module u8t_obuf (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  u8t_pkg::out_t in_result,
    output logic          can_take,
    output logic          m_valid,
    input  logic          m_ready,
    output u8t_pkg::out_t m_data
);
    import u8t_pkg::*;

    logic valid_reg;
    out_t data_reg;

    // a new request may enter when the slot is empty or drains this cycle
    assign can_take = ~valid_reg | m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_fire) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            data_reg <= in_result;
        end
    end

endmodule

// ===== sv/uart_8n1_half_duplex_transceiver.sv =====
// Top level of the 8N1 half-duplex serial transceiver.
// Depends on u8t_pkg, u8t_core and u8t_obuf.
//
// Usage:
//   s_ channel: one request per system tick of the serial line: the sampled
//     rx_line level plus an optional transmit request with its byte.
//   m_ channel: exactly one result per request: tx_line level, last good
//     received byte, a one-request rx_valid strobe and the busy flags.
//   cfg channel: cfg_index 0 writes bit_period, 1 writes half_bit_period;
//     other indexes are ignored. Always ready; write only while idle.
// Result: registered; it appears on m_ in the cycle after its request is accepted.
// Throughput: one request per cycle; the timer and shifters update in a
//   single pass from the registered state, so the only limit is the
//   one-entry result register.
// Reset: aresetn low clears the line to mark, the frame state to idle, the
//   held byte to zero and the periods to 104 and 52 ticks.
// Stall: while a result waits and m_ready is low, s_ready drops and the
//   frame state holds, so no serial tick is lost or repeated.
module uart_8n1_half_duplex_transceiver (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  u8t_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output u8t_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import u8t_pkg::*;

    logic [15:0] bit_period_reg;
    logic [15:0] half_period_reg;
    logic        in_fire;
    logic        can_take;
    out_t        core_result;

    assign cfg_ready = 1'b1;
    assign s_ready   = can_take;
    assign in_fire   = s_valid & can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg  <= RESET_BIT_PERIOD;
            half_period_reg <= RESET_HALF_PERIOD;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    u8t_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_fire         (in_fire),
        .in_data         (s_data),
        .bit_period      (bit_period_reg),
        .half_bit_period (half_period_reg),
        .result          (core_result)
    );

    u8t_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_result (core_result),
        .can_take  (can_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
